>>> rtl/core/epl_pkg.sv
// ----------------------------------------------------------------------------
// epl_pkg: shared types and constants of the estop and park lock controller
// Holds the phase, sound and request codes, the config register indexes and
// reset values, and the structs passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package epl_pkg;

  // request types
  localparam logic REQ_PARK = 1'b0;
  localparam logic REQ_STOP = 1'b1;

  // stop machine phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_READY   = 2'd1;
  localparam logic [1:0] PH_BRAKING = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  // sound events
  localparam logic [1:0] SND_NONE   = 2'd0;
  localparam logic [1:0] SND_LOCK   = 2'd1;
  localparam logic [1:0] SND_UNLOCK = 2'd2;

  // config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_READY_MS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_HOLD_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_HOLD_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CREEP_THROTTLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_THROTTLE  = 3'd6;

  // config reset values
  localparam logic [15:0]       RST_READY_MS        = 16'd500;
  localparam logic [15:0]       RST_BRAKE_MS        = 16'd1500;
  localparam logic [15:0]       RST_UNLOCK_HOLD_MS  = 16'd1000;
  localparam logic [15:0]       RST_LOCK_HOLD_MS    = 16'd500;
  localparam logic [11:0]       RST_PRESS_THRESHOLD = 12'd1500;
  localparam logic signed [7:0] RST_CREEP_THROTTLE  = 8'sd15;
  localparam logic signed [7:0] RST_BRAKE_THROTTLE  = -8'sd100;

  typedef struct packed {
    logic [15:0]       ready_ms;
    logic [15:0]       brake_ms;
    logic [15:0]       unlock_hold_ms;
    logic [15:0]       lock_hold_ms;
    logic [11:0]       press_threshold;
    logic signed [7:0] creep_throttle;
    logic signed [7:0] brake_throttle;
  } cfg_t;

  typedef struct packed {
    logic [1:0] stop_state;
    logic       button_held;
    logic       action_done;
    logic       lock_flag;
  } ctrl_t;

  typedef struct packed {
    logic signed [7:0] throttle_out;
    logic              throttle_written;
    logic              park_locked;
    logic [1:0]        stop_phase;
    logic [1:0]        sound_event;
  } result_t;

endpackage

>>> rtl/core/estop_and_park_lock_controller.sv
// ----------------------------------------------------------------------------
// estop_and_park_lock_controller: emergency stop and park lock controller
// Qualifies park button holds to toggle the park lock, and steps a four-phase
// emergency stop machine that overrides the throttle. One result per request.
// ----------------------------------------------------------------------------
// datapath: an accepted request goes into the input register, then through the
//   step logic into the result register
// throughput: one transaction per cycle unless the result is stalled by out_ready,
//   set by the single step stage that reads and updates the controller state in the same cycle
// reset: synchronous active-low rst_n clears the pipeline valids and all
//   controller state and loads the config registers with their defaults
module estop_and_park_lock_controller #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [epl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [31:0]                     in_now_ms,
  input  logic [11:0]                     in_park_pwm,
  input  logic signed [7:0]               in_throttle_in,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [7:0]               out_throttle_out,
  output logic                            out_throttle_written,
  output logic                            out_park_locked,
  output logic [1:0]                      out_stop_phase,
  output logic [1:0]                      out_sound_event
);
  import epl_pkg::*;

  // config registers
  cfg_t cfg_r;

  // controller state
  ctrl_t                ctrl_r;
  ctrl_t                ctrl_nxt;
  logic [TIME_BITS-1:0] stop_start_r;
  logic [TIME_BITS-1:0] stop_start_nxt;
  logic [TIME_BITS-1:0] press_start_r;
  logic [TIME_BITS-1:0] press_start_nxt;

  // input register stage
  logic                 in_vld_r;
  logic                 in_req_r;
  logic [TIME_BITS-1:0] in_now_r;
  logic [11:0]          in_pwm_r;
  logic signed [7:0]    in_thr_r;

  // result register stage
  logic                 out_vld_r;
  result_t              res_nxt;
  result_t              res_r;

  logic in_take;
  logic advance;

  // the step fires whenever a request is staged and the result slot is free
  // or being drained this cycle
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  // config writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_ms        <= RST_READY_MS;
      cfg_r.brake_ms        <= RST_BRAKE_MS;
      cfg_r.unlock_hold_ms  <= RST_UNLOCK_HOLD_MS;
      cfg_r.lock_hold_ms    <= RST_LOCK_HOLD_MS;
      cfg_r.press_threshold <= RST_PRESS_THRESHOLD;
      cfg_r.creep_throttle  <= RST_CREEP_THROTTLE;
      cfg_r.brake_throttle  <= RST_BRAKE_THROTTLE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READY_MS:        cfg_r.ready_ms        <= cfg_wdata;
        CFG_BRAKE_MS:        cfg_r.brake_ms        <= cfg_wdata;
        CFG_UNLOCK_HOLD_MS:  cfg_r.unlock_hold_ms  <= cfg_wdata;
        CFG_LOCK_HOLD_MS:    cfg_r.lock_hold_ms    <= cfg_wdata;
        CFG_PRESS_THRESHOLD: cfg_r.press_threshold <= cfg_wdata[11:0];
        CFG_CREEP_THROTTLE:  cfg_r.creep_throttle  <= cfg_wdata[7:0];
        CFG_BRAKE_THROTTLE:  cfg_r.brake_throttle  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // input stage payload, timestamp taken modulo 2^TIME_BITS
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r <= in_req_type;
      in_now_r <= TIME_BITS'(in_now_ms);
      in_pwm_r <= in_park_pwm;
      in_thr_r <= in_throttle_in;
    end
  end

  epl_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg             (cfg_r),
    .ctrl            (ctrl_r),
    .stop_start      (stop_start_r),
    .press_start     (press_start_r),
    .req_type        (in_req_r),
    .now             (in_now_r),
    .park_pwm        (in_pwm_r),
    .throttle_in     (in_thr_r),
    .ctrl_nxt        (ctrl_nxt),
    .stop_start_nxt  (stop_start_nxt),
    .press_start_nxt (press_start_nxt),
    .res             (res_nxt)
  );

  // controller state commits on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r        <= '0;
      stop_start_r  <= '0;
      press_start_r <= '0;
    end else if (advance) begin
      ctrl_r        <= ctrl_nxt;
      stop_start_r  <= stop_start_nxt;
      press_start_r <= press_start_nxt;
    end
  end

  // result stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_throttle_out     = res_r.throttle_out;
  assign out_throttle_written = res_r.throttle_written;
  assign out_park_locked      = res_r.park_locked;
  assign out_stop_phase       = res_r.stop_phase;
  assign out_sound_event      = res_r.sound_event;

  // a lock sound leaves park engaged, an unlock sound leaves drive and idle
  a_sound_matches_lock : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.sound_event != SND_NONE) |->
      ((res_r.sound_event == SND_LOCK) && res_r.park_locked) ||
      ((res_r.sound_event == SND_UNLOCK) && !res_r.park_locked &&
       (res_r.stop_phase == PH_IDLE)))
    else $error("sound event inconsistent with lock state");

  // throttle override and sound never come from the same transaction
  a_override_no_sound : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.throttle_written |-> (res_r.sound_event == SND_NONE))
    else $error("throttle override together with sound event");

  // lock flag only moves on a park update step
  a_lock_on_park_only : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (ctrl_r.lock_flag != $past(ctrl_r.lock_flag)) |->
      $past(advance) && ($past(in_req_r) == REQ_PARK))
    else $error("lock flag changed outside a park update");

  // a staged request is never dropped while waiting
  a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("staged request lost");

  // a stalled result is kept until taken
  a_result_kept : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && (res_r == $past(res_r)))
    else $error("pending result overwritten");

endmodule

>>> rtl/core/epl_step.sv
// ----------------------------------------------------------------------------
// epl_step: next-state and result logic for one transaction
// Park button timing with lock toggling, and the four-phase emergency stop
// machine with throttle override. Purely combinational.
// ----------------------------------------------------------------------------
module epl_step #(
  parameter int TIME_BITS = 32
) (
  input  epl_pkg::cfg_t    cfg,
  input  epl_pkg::ctrl_t   ctrl,
  input  logic [TIME_BITS-1:0] stop_start,
  input  logic [TIME_BITS-1:0] press_start,
  input  logic             req_type,
  input  logic [TIME_BITS-1:0] now,
  input  logic [11:0]      park_pwm,
  input  logic signed [7:0] throttle_in,
  output epl_pkg::ctrl_t   ctrl_nxt,
  output logic [TIME_BITS-1:0] stop_start_nxt,
  output logic [TIME_BITS-1:0] press_start_nxt,
  output epl_pkg::result_t res
);
  import epl_pkg::*;

  logic [TIME_BITS-1:0] press_el;
  logic [TIME_BITS-1:0] stop_el;
  logic                 thr_pos;

  // wrapping elapsed times
  assign press_el = now - press_start;
  assign stop_el  = now - stop_start;
  assign thr_pos  = (throttle_in != 8'sd0) && !throttle_in[7];

  always_comb begin
    ctrl_nxt         = ctrl;
    stop_start_nxt   = stop_start;
    press_start_nxt  = press_start;
    res.throttle_out     = throttle_in;
    res.throttle_written = 1'b0;
    res.sound_event      = SND_NONE;

    if (req_type == REQ_PARK) begin
      if (park_pwm > cfg.press_threshold) begin
        if (!ctrl.button_held) begin
          // first pressed update only starts timing
          ctrl_nxt.button_held = 1'b1;
          ctrl_nxt.action_done = 1'b0;
          press_start_nxt      = now;
        end else if (!ctrl.action_done) begin
          if (ctrl.lock_flag) begin
            if (press_el >= TIME_BITS'(cfg.unlock_hold_ms)) begin
              ctrl_nxt.lock_flag   = 1'b0;
              ctrl_nxt.stop_state  = PH_IDLE;
              ctrl_nxt.action_done = 1'b1;
              res.sound_event      = SND_UNLOCK;
            end
          end else if (press_el >= TIME_BITS'(cfg.lock_hold_ms)) begin
            ctrl_nxt.lock_flag   = 1'b1;
            ctrl_nxt.action_done = 1'b1;
            res.sound_event      = SND_LOCK;
          end
        end
      end else begin
        ctrl_nxt.button_held = 1'b0;
        ctrl_nxt.action_done = 1'b0;
      end
    end else if (!ctrl.lock_flag && (ctrl.stop_state == PH_DONE)) begin
      ctrl_nxt.stop_state = PH_IDLE;
    end else begin
      case (ctrl.stop_state)
        PH_IDLE: begin
          if (thr_pos) begin
            res.throttle_out     = cfg.creep_throttle;
            res.throttle_written = 1'b1;
            ctrl_nxt.stop_state  = PH_READY;
            stop_start_nxt       = now;
          end else begin
            ctrl_nxt.stop_state = PH_DONE;
          end
        end
        PH_READY: begin
          if (stop_el >= TIME_BITS'(cfg.ready_ms)) begin
            res.throttle_out     = cfg.brake_throttle;
            res.throttle_written = 1'b1;
            ctrl_nxt.stop_state  = PH_BRAKING;
            stop_start_nxt       = now;
          end
        end
        PH_BRAKING: begin
          if (stop_el >= TIME_BITS'(cfg.brake_ms)) begin
            ctrl_nxt.stop_state = PH_DONE;
          end
        end
        default: begin
          res.throttle_out     = 8'sd0;
          res.throttle_written = 1'b1;
        end
      endcase
    end

    res.park_locked = ctrl_nxt.lock_flag;
    res.stop_phase  = ctrl_nxt.stop_state;
  end

endmodule

>>> verif/tb_estop_and_park_lock_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_estop_and_park_lock_controller: self-checking bench for the estop/park lock
// Drives park updates and stop steps through a valid/ready channel with random
// gaps on both sides. A cycle-free software copy of the controller predicts
// every status transaction. A directed table is followed by random button holds
// and stop runs under several register settings.
// ----------------------------------------------------------------------------
module tb_estop_and_park_lock_controller;
  import epl_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RAND_PHASES    = 6;
  localparam int ITEMS_PER_PHASE = 171;
  localparam int N_DIRECTED     = 29;

  // index 7 has no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_req_type;
  logic [31:0]            in_now_ms;
  logic [11:0]            in_park_pwm;
  logic signed [7:0]      in_throttle_in;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [7:0]      out_throttle_out;
  logic                   out_throttle_written;
  logic                   out_park_locked;
  logic [1:0]             out_stop_phase;
  logic [1:0]             out_sound_event;

  estop_and_park_lock_controller uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_now_ms            (in_now_ms),
    .in_park_pwm          (in_park_pwm),
    .in_throttle_in       (in_throttle_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_throttle_out     (out_throttle_out),
    .out_throttle_written (out_throttle_written),
    .out_park_locked      (out_park_locked),
    .out_stop_phase       (out_stop_phase),
    .out_sound_event      (out_sound_event)
  );

  // --------------------------------------------------------------------------
  // directed table
  // a ROW_CFG row writes a register: now_ms carries the data, park_pwm[2:0]
  // carries the register index; has_want marks rows with a typed-in status
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_PARK, ROW_STOP, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [31:0]       now_ms;
    logic [11:0]       park_pwm;
    logic signed [7:0] throttle;
    logic              has_want;
    result_t           want;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // stop from idle with non-positive throttle goes straight to done
    '{ROW_STOP, 32'd0,        12'd0,    8'sh80,   1'b1,
      '{8'sh80,   1'b0, 1'b0, PH_DONE,    SND_NONE}},
    // done while unlocked falls back to idle, throttle passes through
    '{ROW_STOP, 32'd10,       12'd0,    8'sd127,  1'b1,
      '{8'sd127,  1'b0, 1'b0, PH_IDLE,    SND_NONE}},
    // positive throttle starts the stop with creep throttle
    '{ROW_STOP, 32'd20,       12'd0,    8'sd100,  1'b1,
      '{8'sd15,   1'b1, 1'b0, PH_READY,   SND_NONE}},
    // one ms short of ready time
    '{ROW_STOP, 32'd519,      12'd0,    -8'sd100, 1'b0, '0},
    '{ROW_STOP, 32'd520,      12'd0,    -8'sd1,   1'b1,
      '{-8'sd100, 1'b1, 1'b0, PH_BRAKING, SND_NONE}},
    // one ms short of brake time, then done
    '{ROW_STOP, 32'd2019,     12'd0,    8'sd7,    1'b0, '0},
    '{ROW_STOP, 32'd2020,     12'd0,    8'sd1,    1'b0, '0},
    // pwm equal to threshold is not a press
    '{ROW_PARK, 32'd2100,     12'd1500, 8'sd0,    1'b0, '0},
    '{ROW_PARK, 32'd3000,     12'd1501, -8'sd100, 1'b0, '0},
    '{ROW_PARK, 32'd3499,     12'd4095, 8'sd100,  1'b0, '0},
    // hold reaches lock time exactly
    '{ROW_PARK, 32'd3500,     12'd1501, 8'sd0,    1'b1,
      '{8'sd0,    1'b0, 1'b1, PH_DONE,    SND_LOCK}},
    // same press never acts twice
    '{ROW_PARK, 32'd9000,     12'd4095, 8'sd0,    1'b0, '0},
    // done while locked keeps overriding with zero
    '{ROW_STOP, 32'd9001,     12'd0,    8'sd100,  1'b1,
      '{8'sd0,    1'b1, 1'b1, PH_DONE,    SND_NONE}},
    '{ROW_PARK, 32'd9002,     12'd0,    8'sd0,    1'b0, '0},
    // unlock hold measured across the timestamp wrap
    '{ROW_PARK, 32'hFFFF_FE00, 12'd2000, 8'sd0,   1'b0, '0},
    '{ROW_PARK, 32'h0000_01E7, 12'd2000, 8'sd0,   1'b0, '0},
    '{ROW_PARK, 32'h0000_01E8, 12'd2000, -8'sd1,  1'b1,
      '{-8'sd1,   1'b0, 1'b0, PH_IDLE,    SND_UNLOCK}},
    '{ROW_PARK, 32'h0000_0200, 12'd0,    8'sd0,   1'b0, '0},
    // ready time measured across the wrap
    '{ROW_STOP, 32'hFFFF_FFF0, 12'd0,    8'sd1,   1'b0, '0},
    '{ROW_STOP, 32'h0000_0100, 12'd0,    8'sd0,   1'b0, '0},
    '{ROW_STOP, 32'h0000_01E4, 12'd0,    8'sd0,   1'b0, '0},
    // zero hold times, and a write to the unused index
    '{ROW_CFG,  32'd0,        12'(CFG_LOCK_HOLD_MS),   8'sd0, 1'b0, '0},
    '{ROW_CFG,  32'd0,        12'(CFG_UNLOCK_HOLD_MS), 8'sd0, 1'b0, '0},
    '{ROW_CFG,  32'hFFFF,     12'(CFG_UNUSED_IDX),     8'sd0, 1'b0, '0},
    // first pressed update only starts timing, even with zero hold
    '{ROW_PARK, 32'd5,        12'd4000, 8'sd0,    1'b0, '0},
    '{ROW_PARK, 32'd5,        12'd4000, 8'sd0,    1'b0, '0},
    '{ROW_PARK, 32'd5,        12'd0,    8'sd0,    1'b0, '0},
    '{ROW_PARK, 32'd5,        12'd4000, 8'sd0,    1'b0, '0},
    '{ROW_PARK, 32'd5,        12'd4000, 8'sd0,    1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // controller copy: register shadow plus stop machine and button state
  // --------------------------------------------------------------------------
  cfg_t        live_cfg;
  logic [1:0]  stop_phase_r;
  logic [31:0] stop_t0;
  logic [31:0] press_t0;
  logic        button_down;
  logic        hold_used;
  logic        park_lock;

  result_t     pending_status [$];
  int          mismatches;
  logic        sender_steady;
  logic        receiver_steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_controller_copy();
    live_cfg.ready_ms        = RST_READY_MS;
    live_cfg.brake_ms        = RST_BRAKE_MS;
    live_cfg.unlock_hold_ms  = RST_UNLOCK_HOLD_MS;
    live_cfg.lock_hold_ms    = RST_LOCK_HOLD_MS;
    live_cfg.press_threshold = RST_PRESS_THRESHOLD;
    live_cfg.creep_throttle  = RST_CREEP_THROTTLE;
    live_cfg.brake_throttle  = RST_BRAKE_THROTTLE;
    stop_phase_r = PH_IDLE;
    stop_t0      = '0;
    press_t0     = '0;
    button_down  = 1'b0;
    hold_used    = 1'b0;
    park_lock    = 1'b0;
  endfunction

  // computes the status of one request and advances the copy
  function automatic result_t next_controller_status(input logic req,
                                                     input logic [31:0] now,
                                                     input logic [11:0] pwm,
                                                     input logic signed [7:0] thr);
    result_t     st;
    logic [31:0] held_for;
    logic [31:0] in_phase;
    st.throttle_out     = thr;
    st.throttle_written = 1'b0;
    st.sound_event      = SND_NONE;
    held_for = now - press_t0;
    in_phase = now - stop_t0;
    if (req == REQ_PARK) begin
      if (pwm > live_cfg.press_threshold) begin
        if (!button_down) begin
          // rising edge only starts the hold timer
          button_down = 1'b1;
          press_t0    = now;
          hold_used   = 1'b0;
        end else if (!hold_used) begin
          if (park_lock) begin
            if (held_for >= 32'(live_cfg.unlock_hold_ms)) begin
              park_lock      = 1'b0;
              stop_phase_r   = PH_IDLE;
              hold_used      = 1'b1;
              st.sound_event = SND_UNLOCK;
            end
          end else if (held_for >= 32'(live_cfg.lock_hold_ms)) begin
            park_lock      = 1'b1;
            hold_used      = 1'b1;
            st.sound_event = SND_LOCK;
          end
        end
      end else begin
        button_down = 1'b0;
        hold_used   = 1'b0;
      end
    end else if (!park_lock && stop_phase_r == PH_DONE) begin
      stop_phase_r = PH_IDLE;
    end else begin
      case (stop_phase_r)
        PH_IDLE: begin
          if (thr > 0) begin
            st.throttle_out     = live_cfg.creep_throttle;
            st.throttle_written = 1'b1;
            stop_phase_r        = PH_READY;
            stop_t0             = now;
          end else begin
            stop_phase_r = PH_DONE;
          end
        end
        PH_READY: begin
          if (in_phase >= 32'(live_cfg.ready_ms)) begin
            st.throttle_out     = live_cfg.brake_throttle;
            st.throttle_written = 1'b1;
            stop_phase_r        = PH_BRAKING;
            stop_t0             = now;
          end
        end
        PH_BRAKING: begin
          if (in_phase >= 32'(live_cfg.brake_ms)) stop_phase_r = PH_DONE;
        end
        default: begin
          st.throttle_out     = '0;
          st.throttle_written = 1'b1;
        end
      endcase
    end
    st.park_locked = park_lock;
    st.stop_phase  = stop_phase_r;
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // hold off the sender until every outstanding status has come back
  task automatic wait_for_status_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
  endtask

  // register writes only happen with the controller idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_status_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_READY_MS:        live_cfg.ready_ms        = data;
      CFG_BRAKE_MS:        live_cfg.brake_ms        = data;
      CFG_UNLOCK_HOLD_MS:  live_cfg.unlock_hold_ms  = data;
      CFG_LOCK_HOLD_MS:    live_cfg.lock_hold_ms    = data;
      CFG_PRESS_THRESHOLD: live_cfg.press_threshold = data[11:0];
      CFG_CREEP_THROTTLE:  live_cfg.creep_throttle  = data[7:0];
      CFG_BRAKE_THROTTLE:  live_cfg.brake_throttle  = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // narrow registers get random upper data bits, which must be dropped
  task automatic program_settings(input cfg_t s);
    write_register(CFG_READY_MS, s.ready_ms);
    write_register(CFG_BRAKE_MS, s.brake_ms);
    write_register(CFG_UNLOCK_HOLD_MS, s.unlock_hold_ms);
    write_register(CFG_LOCK_HOLD_MS, s.lock_hold_ms);
    write_register(CFG_PRESS_THRESHOLD, {4'($urandom), s.press_threshold});
    write_register(CFG_CREEP_THROTTLE, {8'($urandom), s.creep_throttle});
    write_register(CFG_BRAKE_THROTTLE, {8'($urandom), s.brake_throttle});
    write_register(CFG_UNUSED_IDX, 16'($urandom));
  endtask

  // one request transaction; the status is predicted at the accepting edge
  task automatic send_request(input logic req, input logic [31:0] now,
                              input logic [11:0] pwm, input logic signed [7:0] thr,
                              input logic has_want, input result_t want);
    int      gap;
    result_t predicted;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_now_ms      <= now;
    in_park_pwm    <= pwm;
    in_throttle_in <= thr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_controller_status(req, now, pwm, thr);
    pending_status.push_back(has_want ? want : predicted);
  endtask

  // --------------------------------------------------------------------------
  // stimulus: reset, directed table, then random phases under new settings
  // --------------------------------------------------------------------------
  initial begin
    int                phase;
    int                n;
    int                scale;
    int                press_left;
    int                thresh;
    logic              holding;
    logic              req;
    logic [31:0]       now;
    logic [11:0]       pwm;
    logic signed [7:0] thr;
    cfg_t              setting;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_req_type    = REQ_PARK;
    in_now_ms      = '0;
    in_park_pwm    = '0;
    in_throttle_in = '0;
    mismatches     = 0;
    sender_steady  = 1'b0;
    reset_controller_copy();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (n = 0; n < N_DIRECTED; n++) begin
      if (directed_rows[n].kind == ROW_CFG) begin
        write_register(directed_rows[n].park_pwm[CFG_IDX_W-1:0],
                       directed_rows[n].now_ms[CFG_DATA_W-1:0]);
      end else begin
        send_request(directed_rows[n].kind == ROW_STOP ? REQ_STOP : REQ_PARK,
                     directed_rows[n].now_ms, directed_rows[n].park_pwm,
                     directed_rows[n].throttle, directed_rows[n].has_want,
                     directed_rows[n].want);
      end
    end

    // random phases, each under its own register setting
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin
          setting = '{RST_READY_MS, RST_BRAKE_MS, RST_UNLOCK_HOLD_MS, RST_LOCK_HOLD_MS,
                      RST_PRESS_THRESHOLD, RST_CREEP_THROTTLE, RST_BRAKE_THROTTLE};
        end
        1: begin
          // zero times, every pwm but zero is a press
          setting = '{16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 8'sd100, -8'sd100};
        end
        2: begin
          // longest times, nothing can be a press
          setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, -8'sd100, 8'sd100};
        end
        3: begin
          setting.ready_ms        = 16'($urandom_range(0, 100));
          setting.brake_ms        = 16'($urandom_range(0, 100));
          setting.unlock_hold_ms  = 16'($urandom_range(0, 100));
          setting.lock_hold_ms    = 16'($urandom_range(0, 100));
          setting.press_threshold = 12'($urandom);
          setting.creep_throttle  = 8'($urandom);
          setting.brake_throttle  = 8'($urandom);
        end
        4: begin
          setting.ready_ms        = 16'($urandom);
          setting.brake_ms        = 16'($urandom);
          setting.unlock_hold_ms  = 16'($urandom);
          setting.lock_hold_ms    = 16'($urandom);
          setting.press_threshold = 12'd4094;
          setting.creep_throttle  = 8'sh7F;
          setting.brake_throttle  = 8'sh80;
        end
        default: begin
          setting.ready_ms        = 16'($urandom_range(0, 3000));
          setting.brake_ms        = 16'($urandom_range(0, 3000));
          setting.unlock_hold_ms  = 16'($urandom_range(0, 3000));
          setting.lock_hold_ms    = 16'($urandom_range(0, 3000));
          setting.press_threshold = 12'($urandom_range(0, 4095));
          setting.creep_throttle  = 8'($urandom_range(0, 200) - 100);
          setting.brake_throttle  = 8'($urandom_range(0, 200) - 100);
        end
      endcase
      program_settings(setting);

      // time steps sized so holds and stop phases finish in a few requests
      scale = int'(setting.ready_ms);
      if (int'(setting.brake_ms) > scale) scale = int'(setting.brake_ms);
      if (int'(setting.unlock_hold_ms) > scale) scale = int'(setting.unlock_hold_ms);
      if (int'(setting.lock_hold_ms) > scale) scale = int'(setting.lock_hold_ms);
      scale = scale / 3 + 1;
      thresh = int'(live_cfg.press_threshold);
      // about half the phases start just short of the timestamp wrap
      now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - 32'($urandom_range(0, scale * 40));
      press_left = 0;
      holding    = 1'b0;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 31) == 0) sender_steady = !sender_steady;
        if ($urandom_range(0, 49) == 0) wait_for_status_drain();

        case ($urandom_range(0, 19))
          0:       now = $urandom;
          1:       ;
          default: now = now + 32'($urandom_range(0, scale));
        endcase

        // button runs: long pressed stretches with short releases between
        if (press_left == 0) begin
          holding    = ($urandom_range(0, 2) != 0);
          press_left = holding ? $urandom_range(2, 10) : $urandom_range(1, 3);
        end

        req = $urandom_range(0, 1) ? REQ_STOP : REQ_PARK;
        if (req == REQ_STOP) begin
          case ($urandom_range(0, 9))
            0:       thr = 8'($urandom);
            1, 2:    thr = -8'($urandom_range(0, 100));
            default: thr = 8'($urandom_range(1, 100));
          endcase
          pwm = 12'($urandom);
        end else begin
          press_left--;
          thr = 8'($urandom_range(0, 200) - 100);
          if ($urandom_range(0, 19) == 0) begin
            pwm = 12'($urandom);
          end else if (holding && thresh != 4095) begin
            pwm = $urandom_range(0, 3) == 0 ? 12'(thresh + 1)
                                             : 12'($urandom_range(thresh + 1, 4095));
          end else begin
            pwm = $urandom_range(0, 3) == 0 ? 12'(thresh) : 12'($urandom_range(0, thresh));
          end
        end
        send_request(req, now, pwm, thr, 1'b0, '0);
      end
    end

    // let the last status transactions drain, then idle before the final check
    wait_for_status_drain();
    repeat (8) @(negedge clk);
    mismatches += pending_status.size();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: random stall before each status transaction
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    out_ready       = 1'b0;
    receiver_steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_steady = !receiver_steady;
      gap = receiver_steady ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // checker: each status transaction against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic compare_field(input string field, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected status, expected none, actual throttle %0d phase %0d",
                 $time, out_throttle_out, out_stop_phase);
      end else begin
        want = pending_status.pop_front();
        compare_field("throttle_out", want.throttle_out, out_throttle_out);
        compare_field("throttle_written", {31'd0, want.throttle_written},
                      {31'd0, out_throttle_written});
        compare_field("park_locked", {31'd0, want.park_locked}, {31'd0, out_park_locked});
        compare_field("stop_phase", {30'd0, want.stop_phase}, {30'd0, out_stop_phase});
        compare_field("sound_event", {30'd0, want.sound_event}, {30'd0, out_sound_event});
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too many cycles without any transaction ends the run
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
